// ----- src/fmsf_pkg.sv -----
// shared types and constants for the frame motion scrub flagger
// used by frame_motion_scrub_flagger_top; depends on nothing else
`default_nettype none

package fmsf_pkg;

  // field widths
  localparam int unsigned PARAM_W   = 24;
  localparam int unsigned DVARS_W   = 17;
  localparam int unsigned FD_W      = 27;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned NUM_PARAM = 6;

  // sum of three absolute differences of 24 bit values fits in 26 bits
  localparam int unsigned SUM_W  = 26;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned PROD_W = SUM_W + FRAC_W;
  localparam int unsigned TOT_W  = FD_W + 1;

  // pi * 50 / 180 in Q16, and half an lsb for rounding
  localparam logic [FRAC_W-1:0] DEG_TO_MM_Q16 = 16'd57191;
  localparam logic [PROD_W-1:0] ROUND_HALF    = PROD_W'(32768);
  localparam logic [FD_W-1:0]   FD_MAX        = {FD_W{1'b1}};

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = FD_W;
  localparam logic [FD_W-1:0]    FD_THR_RESET    = 27'd4096;
  localparam logic [DVARS_W-1:0] DVARS_THR_RESET = 17'd3277;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FD_THR    = 1'b0,
    CFG_DVARS_THR = 1'b1
  } cfg_idx_e;

  localparam int unsigned MAX_FRAMES_DEFAULT = 4096;

  // result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  // input register contents: tx, ty, tz, pitch, roll, yaw in that order
  typedef struct packed {
    logic [NUM_PARAM-1:0][PARAM_W-1:0] params;
    logic [DVARS_W-1:0]                dvars;
    logic                              final_frame;
  } s1_t;

  // after absolute differences and sums
  typedef struct packed {
    logic [SUM_W-1:0] trans_sum;
    logic [SUM_W-1:0] rot_sum;
    logic             dvars_exc;
    logic             first;
    logic             final_frame;
  } s2_t;

  // after the arc length scaling
  typedef struct packed {
    logic [SUM_W-1:0] trans_sum;
    logic [SUM_W-1:0] rot_mm;
    logic             dvars_exc;
    logic             first;
    logic             final_frame;
  } s3_t;

  typedef struct packed {
    logic [IDX_W-1:0] frame_index;
    logic             flagged;
    logic [FD_W-1:0]  displacement;
    logic             last_result;
  } res_t;

  // absolute difference of two signed 24 bit values
  function automatic logic [PARAM_W-1:0] abs_diff(input logic [PARAM_W-1:0] a,
                                                  input logic [PARAM_W-1:0] b);
    logic [PARAM_W:0] d;
    logic [PARAM_W:0] m;
    d = {a[PARAM_W-1], a} - {b[PARAM_W-1], b};
    m = d[PARAM_W] ? (~d + 1'b1) : d;
    return m[PARAM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/frame_motion_scrub_flagger_top.sv -----
// A frame's result enters the output queue when the request that follows it
// leaves stage 3 (the final frame's own result comes with its predecessor's).
// One request per cycle while the result queue has room; a final frame not
// first in its series pushes two results. Stalls come only from the 4-entry
// result queue. Reset clears series counters and flags, restores thresholds.
// top level: three stage datapath for framewise displacement and scrub flags
// depends on fmsf_pkg
`default_nettype none

module frame_motion_scrub_flagger_top #(
  parameter int unsigned MAX_FRAMES = fmsf_pkg::MAX_FRAMES_DEFAULT
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // configuration
  input  wire logic                                   cfg_we_i,
  input  wire logic [fmsf_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [fmsf_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  // frame requests
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic signed [fmsf_pkg::PARAM_W-1:0]    trans_x_i,
  input  wire logic signed [fmsf_pkg::PARAM_W-1:0]    trans_y_i,
  input  wire logic signed [fmsf_pkg::PARAM_W-1:0]    trans_z_i,
  input  wire logic signed [fmsf_pkg::PARAM_W-1:0]    rot_pitch_i,
  input  wire logic signed [fmsf_pkg::PARAM_W-1:0]    rot_roll_i,
  input  wire logic signed [fmsf_pkg::PARAM_W-1:0]    rot_yaw_i,
  input  wire logic [fmsf_pkg::DVARS_W-1:0]           dvars_value_i,
  input  wire logic                                   final_frame_i,
  // results
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic [fmsf_pkg::IDX_W-1:0]                  frame_index_o,
  output logic                                        flagged_o,
  output logic [fmsf_pkg::FD_W-1:0]                   displacement_o,
  output logic                                        last_result_o
);
  import fmsf_pkg::*;

  localparam int unsigned CNT_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_FRAMES - 1);

  // configuration registers
  logic [FD_W-1:0]    fd_thr_q;
  logic [DVARS_W-1:0] dvars_thr_q;

  // pipeline registers
  logic s1_valid_q, s2_valid_q, s3_valid_q;
  s1_t  s1_q, s1_d;
  s2_t  s2_q, s2_d;
  s3_t  s3_q, s3_d;
  logic advance;

  // series state
  logic                              running_q;
  logic [NUM_PARAM-1:0][PARAM_W-1:0] prev_q;
  logic [CNT_W-1:0]                  frame_cnt_q, frame_cnt_d;
  logic [FD_W-1:0]                   pend_fd_q;
  logic                              exc_prev_q, exc_prev2_q;

  // result queue
  res_t                  fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] fifo_cnt_q;
  logic                  pop;
  logic [1:0]            n_push;
  res_t                  res_prev, res_last, push0;

  // stage 3 arithmetic
  logic [TOT_W-1:0] total;
  logic [FD_W-1:0]  fd;
  logic             exceed;
  logic             s1_fire, s3_fire;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_thr_q    <= FD_THR_RESET;
      dvars_thr_q <= DVARS_THR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FD_THR:    fd_thr_q    <= cfg_wdata_i;
        CFG_DVARS_THR: dvars_thr_q <= cfg_wdata_i[DVARS_W-1:0];
        default:       fd_thr_q    <= fd_thr_q;
      endcase
    end
  end

  // whole pipe moves together; hold when the queue cannot take two results
  assign advance    = !s3_valid_q || (fifo_cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign in_ready_o = advance;
  assign s1_fire    = advance && s1_valid_q;
  assign s3_fire    = advance && s3_valid_q;

  // stage 1 input capture
  always_comb begin
    s1_d.params      = {rot_yaw_i, rot_roll_i, rot_pitch_i, trans_z_i, trans_y_i, trans_x_i};
    s1_d.dvars       = dvars_value_i;
    s1_d.final_frame = final_frame_i;
  end

  // stage 1 to 2: absolute differences against the previous frame
  always_comb begin
    logic [SUM_W-1:0] t_sum;
    logic [SUM_W-1:0] r_sum;
    t_sum = '0;
    r_sum = '0;
    for (int i = 0; i < 3; i++) begin
      t_sum = t_sum + SUM_W'(abs_diff(s1_q.params[i], prev_q[i]));
      r_sum = r_sum + SUM_W'(abs_diff(s1_q.params[i+3], prev_q[i+3]));
    end
    s2_d.trans_sum   = t_sum;
    s2_d.rot_sum     = r_sum;
    s2_d.dvars_exc   = s1_q.dvars > dvars_thr_q;
    s2_d.first       = !running_q;
    s2_d.final_frame = s1_q.final_frame;
  end

  // stage 2 to 3: degrees to arc length, round half up
  always_comb begin
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s2_q.rot_sum) * PROD_W'(DEG_TO_MM_Q16) + ROUND_HALF;
    s3_d.trans_sum   = s2_q.trans_sum;
    s3_d.rot_mm      = prod[FRAC_W +: SUM_W];
    s3_d.dvars_exc   = s2_q.dvars_exc;
    s3_d.first       = s2_q.first;
    s3_d.final_frame = s2_q.final_frame;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  // previous parameters advance with the frame leaving stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
    end else if (s1_fire) begin
      running_q <= !s1_q.final_frame;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      prev_q <= s1_q.params;
    end
  end

  // stage 3: displacement, saturation and threshold compare
  always_comb begin
    total  = TOT_W'(s3_q.trans_sum) + TOT_W'(s3_q.rot_mm);
    fd     = '0;
    exceed = 1'b0;
    if (!s3_q.first) begin
      fd     = (total > TOT_W'(FD_MAX)) ? FD_MAX : total[FD_W-1:0];
      exceed = (fd > fd_thr_q) || s3_q.dvars_exc;
    end
  end

  // frame counter wraps at MAX_FRAMES
  always_comb begin
    frame_cnt_d = (frame_cnt_q == CNT_LAST) ? '0 : frame_cnt_q + 1'b1;
  end

  // result for the pending frame and for a final frame
  always_comb begin
    logic [CNT_W-1:0] prev_idx;
    prev_idx = (frame_cnt_q == '0) ? CNT_LAST : frame_cnt_q - 1'b1;
    res_prev.frame_index  = IDX_W'(prev_idx);
    res_prev.flagged      = exc_prev2_q || exc_prev_q || exceed;
    res_prev.displacement = pend_fd_q;
    res_prev.last_result  = 1'b0;
    res_last.frame_index  = IDX_W'(frame_cnt_q);
    res_last.flagged      = exc_prev_q || exceed;
    res_last.displacement = fd;
    res_last.last_result  = 1'b1;
    push0  = s3_q.first ? res_last : res_prev;
    n_push = 2'd0;
    if (s3_fire) begin
      n_push = {1'b0, !s3_q.first} + {1'b0, s3_q.final_frame};
    end
  end

  // series state update at stage 3
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cnt_q <= '0;
      pend_fd_q   <= '0;
      exc_prev_q  <= 1'b0;
      exc_prev2_q <= 1'b0;
    end else if (s3_fire) begin
      if (s3_q.final_frame) begin
        frame_cnt_q <= '0;
        pend_fd_q   <= '0;
        exc_prev_q  <= 1'b0;
        exc_prev2_q <= 1'b0;
      end else begin
        frame_cnt_q <= frame_cnt_d;
        pend_fd_q   <= fd;
        exc_prev_q  <= exceed;
        exc_prev2_q <= exc_prev_q;
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= push0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + 1'b1] <= res_last;
    end
  end

  // result queue pointers
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_q + FIFO_PTR_W'(n_push);
      rd_ptr_q   <= rd_ptr_q + FIFO_PTR_W'(pop);
      fifo_cnt_q <= fifo_cnt_q + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
    end
  end

  // result outputs
  assign out_valid_o    = fifo_cnt_q != '0;
  assign frame_index_o  = fifo_q[rd_ptr_q].frame_index;
  assign flagged_o      = fifo_q[rd_ptr_q].flagged;
  assign displacement_o = fifo_q[rd_ptr_q].displacement;
  assign last_result_o  = fifo_q[rd_ptr_q].last_result;

`ifndef NO_ASSERTIONS
  // queue never overfills
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // an accepted request lands in stage 1
  a_s1_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid_q)
    else $error("accepted request lost");

  // a final frame ends the series at stage 1
  a_series_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_q.final_frame) |=> !running_q)
    else $error("series still running after final frame");

  // the first frame of a series finds the stage 3 counter cleared
  a_first_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_valid_q && s3_q.first) |-> (frame_cnt_q == '0))
    else $error("frame counter not cleared at series start");
`endif

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// testbench for frame_motion_scrub_flagger_top: directed and random frame series,
// each result checked against an in-bench displacement and scrub flag predictor
// depends on fmsf_pkg and frame_motion_scrub_flagger_top
`timescale 1ns / 1ps

module tb_top;
  import fmsf_pkg::*;

  localparam int PMAX = 8388607;
  localparam int PMIN = -8388608;

  // clock, reset and block ports
  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = CFG_FD_THR;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_ready_o;
  logic signed [PARAM_W-1:0] trans_x_i   = '0;
  logic signed [PARAM_W-1:0] trans_y_i   = '0;
  logic signed [PARAM_W-1:0] trans_z_i   = '0;
  logic signed [PARAM_W-1:0] rot_pitch_i = '0;
  logic signed [PARAM_W-1:0] rot_roll_i  = '0;
  logic signed [PARAM_W-1:0] rot_yaw_i   = '0;
  logic [DVARS_W-1:0]    dvars_value_i = '0;
  logic                  final_frame_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i   = 1'b0;
  logic [IDX_W-1:0]      frame_index_o;
  logic                  flagged_o;
  logic [FD_W-1:0]       displacement_o;
  logic                  last_result_o;

  // predictor state: thresholds and the running series
  logic [FD_W-1:0]                   fd_thr_m    = FD_THR_RESET;
  logic [DVARS_W-1:0]                dvars_thr_m = DVARS_THR_RESET;
  logic [NUM_PARAM-1:0][PARAM_W-1:0] last_params = '0;
  logic [IDX_W-1:0]                  frame_cnt   = '0;
  logic [FD_W-1:0]                   pending_fd  = '0;
  logic                              exc_prev    = 1'b0;
  logic                              exc_prev2   = 1'b0;
  logic                              series_open = 1'b0;

  s1_t  frame_q[$];
  res_t scrub_q[$];

  int unsigned err_cnt = 0;

  frame_motion_scrub_flagger_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .trans_x_i      (trans_x_i),
    .trans_y_i      (trans_y_i),
    .trans_z_i      (trans_z_i),
    .rot_pitch_i    (rot_pitch_i),
    .rot_roll_i     (rot_roll_i),
    .rot_yaw_i      (rot_yaw_i),
    .dvars_value_i  (dvars_value_i),
    .final_frame_i  (final_frame_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_index_o  (frame_index_o),
    .flagged_o      (flagged_o),
    .displacement_o (displacement_o),
    .last_result_o  (last_result_o)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // framewise displacement against the previous frame, rounded and saturated
  function automatic logic [FD_W-1:0] frame_displacement(
      input s1_t f, input logic [NUM_PARAM-1:0][PARAM_W-1:0] prev);
    longint trans_mm;
    longint rot_deg;
    longint total;
    longint d;
    int     i;
    trans_mm = 0;
    rot_deg  = 0;
    for (i = 0; i < NUM_PARAM; i++) begin
      d = longint'($signed(f.params[i])) - longint'($signed(prev[i]));
      if (d < 0) d = -d;
      if (i < 3) trans_mm += d;
      else rot_deg += d;
    end
    total = trans_mm +
            ((rot_deg * longint'(DEG_TO_MM_Q16) + longint'(ROUND_HALF)) >>> FRAC_W);
    if (total > longint'(FD_MAX)) total = longint'(FD_MAX);
    return total[FD_W-1:0];
  endfunction

  // advance the series by one accepted frame and queue the results it releases
  task automatic predict_frame(input s1_t f);
    logic [FD_W-1:0] fd;
    logic            exc;
    res_t            r;
    fd  = '0;
    exc = 1'b0;
    if (series_open) begin
      fd  = frame_displacement(f, last_params);
      exc = (fd > fd_thr_m) || (f.dvars > dvars_thr_m);
      r.frame_index  = frame_cnt - 1'b1;
      r.flagged      = exc_prev2 | exc_prev | exc;
      r.displacement = pending_fd;
      r.last_result  = 1'b0;
      scrub_q.push_back(r);
    end
    if (f.final_frame) begin
      r.frame_index  = frame_cnt;
      r.flagged      = exc_prev | exc;
      r.displacement = fd;
      r.last_result  = 1'b1;
      scrub_q.push_back(r);
      last_params = '0;
      frame_cnt   = '0;
      pending_fd  = '0;
      exc_prev    = 1'b0;
      exc_prev2   = 1'b0;
      series_open = 1'b0;
    end else begin
      last_params = f.params;
      exc_prev2   = exc_prev;
      exc_prev    = exc;
      pending_fd  = fd;
      frame_cnt   = frame_cnt + 1'b1;
      series_open = 1'b1;
    end
  endtask

  // request driver: random gap after each frame, bursts with no gaps
  int unsigned send_gap = 0;
  int unsigned sent_cnt = 0;
  s1_t         offered;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_frame(offered);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap = send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (frame_q.size() != 0) begin
          offered = frame_q.pop_front();
          trans_x_i     <= offered.params[0];
          trans_y_i     <= offered.params[1];
          trans_z_i     <= offered.params[2];
          rot_pitch_i   <= offered.params[3];
          rot_roll_i    <= offered.params[4];
          rot_yaw_i     <= offered.params[5];
          dvars_value_i <= offered.dvars;
          final_frame_i <= offered.final_frame;
          in_valid_i    <= 1'b1;
          sent_cnt++;
          send_gap = sent_cnt[6] ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
      err_cnt++;
    end
  endtask

  // result monitor: random stalls, two long hold-offs to back up the block
  int unsigned rx_wait   = 0;
  int unsigned hold_left = 0;
  int unsigned got_cnt   = 0;
  res_t        want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_cnt++;
        if (scrub_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual index %0d fd %0d",
                   $time, frame_index_o, displacement_o);
          err_cnt++;
        end else begin
          want = scrub_q.pop_front();
          check_field("frame_index", 32'(want.frame_index), 32'(frame_index_o));
          check_field("flagged", 32'(want.flagged), 32'(flagged_o));
          check_field("displacement", 32'(want.displacement), 32'(displacement_o));
          check_field("last_result", 32'(want.last_result), 32'(last_result_o));
        end
        rx_wait = got_cnt[5] ? 0 : $urandom_range(0, 5);
        if (got_cnt == 100 || got_cnt == 1200) hold_left = 150;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push_frame(input int tx, input int ty, input int tz, input int rp,
                            input int rr, input int ry, input int unsigned dv,
                            input bit fin);
    s1_t f;
    f.params[0]   = tx[PARAM_W-1:0];
    f.params[1]   = ty[PARAM_W-1:0];
    f.params[2]   = tz[PARAM_W-1:0];
    f.params[3]   = rp[PARAM_W-1:0];
    f.params[4]   = rr[PARAM_W-1:0];
    f.params[5]   = ry[PARAM_W-1:0];
    f.dvars       = dv[DVARS_W-1:0];
    f.final_frame = fin;
    frame_q.push_back(f);
  endtask

  // one series: a random walk of head motion with the odd jump, or pure noise
  task automatic add_series(input int unsigned len, input bit wild);
    int          pos[NUM_PARAM];
    int          span;
    int unsigned n;
    int          k;
    s1_t         f;
    span = ($urandom_range(0, 4) == 0) ? 20000 : $urandom_range(1, 2500);
    for (k = 0; k < NUM_PARAM; k++) pos[k] = $urandom_range(0, 16777215) - 8388608;
    for (n = 0; n < len; n++) begin
      for (k = 0; k < NUM_PARAM; k++) begin
        if (wild || $urandom_range(0, 40) == 0) begin
          f.params[k] = PARAM_W'($urandom);
          pos[k] = int'($signed(f.params[k]));
        end else begin
          pos[k] = pos[k] + $urandom_range(0, 2 * span) - span;
          if (pos[k] > PMAX) pos[k] = PMAX;
          if (pos[k] < PMIN) pos[k] = PMIN;
          f.params[k] = pos[k][PARAM_W-1:0];
        end
      end
      f.dvars = ($urandom_range(0, 3) == 0) ? DVARS_W'($urandom) :
                DVARS_W'($urandom_range(0, 2 * dvars_thr_m + 2));
      f.final_frame = (n == len - 1);
      frame_q.push_back(f);
    end
  endtask

  task automatic add_random(input int unsigned n_frames);
    int unsigned done;
    int unsigned len;
    done = 0;
    while (done < n_frames) begin
      case ($urandom_range(0, 9))
        0:       len = 1;
        1:       len = $urandom_range(2, 100);
        default: len = $urandom_range(2, 30);
      endcase
      add_series(len, $urandom_range(0, 4) == 0);
      done += len;
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_FD_THR:    fd_thr_m    = val[FD_W-1:0];
      CFG_DVARS_THR: dvars_thr_m = val[DVARS_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // block drained: no frame waiting, none offered, no result outstanding
  task automatic wait_idle();
    do @(posedge clk_i);
    while (frame_q.size() != 0 || in_valid_i || scrub_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  // test sequence
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed, reset thresholds: single-frame series at the extremes
    push_frame(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, 131071, 1'b1);
    // first frame ignores dvars; thresholds hit exactly and then passed
    push_frame(0, 0, 0, 0, 0, 0, 131071, 1'b0);
    push_frame(0, 0, 0, 0, 0, 0, 3277, 1'b0);
    push_frame(4096, 0, 0, 0, 0, 0, 0, 1'b0);
    push_frame(8193, 0, 0, 0, 0, 0, 0, 1'b0);
    push_frame(8193, 0, 0, 0, 0, 0, 3278, 1'b0);
    push_frame(8193, 0, 0, 0, 0, 0, 0, 1'b0);
    push_frame(8193, 0, 0, 0, 0, 0, 0, 1'b0);
    push_frame(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 0, 1'b0);
    push_frame(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, 0, 1'b0);
    push_frame(PMIN, PMIN, PMIN, PMIN + 1, PMIN, PMIN, 0, 1'b0);
    push_frame(PMIN, PMIN, PMIN, PMIN + 1, PMIN, PMIN, 0, 1'b0);
    push_frame(PMIN, PMIN, PMIN, PMIN + 1, PMIN, PMIN, 0, 1'b0);
    push_frame(PMIN, PMIN, PMIN, PMIN + 1, PMIN, PMIN, 0, 1'b1);
    // two-frame series whose final frame exceeds
    push_frame(0, 0, 0, 0, 0, 0, 0, 1'b0);
    push_frame(PMAX, 0, 0, 0, 0, 0, 0, 1'b1);
    // small rotation, dvars at full scale, quiet final frame
    push_frame(0, 0, 0, 0, 0, 0, 0, 1'b0);
    push_frame(0, 0, 0, 0, 1, 0, 0, 1'b0);
    push_frame(0, 0, 0, 0, 0, -1, 131071, 1'b0);
    push_frame(0, 0, 0, 0, 0, 0, 0, 1'b1);
    wait_idle();

    // thresholds at zero: any frame past the first with motion or dvars above zero exceeds
    write_reg(CFG_FD_THR, '0);
    write_reg(CFG_DVARS_THR, '0);
    add_random(250);
    wait_idle();

    // nothing exceeds; high data bits of the dvars write are dropped
    write_reg(CFG_FD_THR, FD_MAX);
    write_reg(CFG_DVARS_THR, {CFG_DATA_W{1'b1}});
    add_random(250);
    wait_idle();

    // reset values again
    write_reg(CFG_FD_THR, CFG_DATA_W'(FD_THR_RESET));
    write_reg(CFG_DVARS_THR, CFG_DATA_W'(DVARS_THR_RESET));
    add_random(250);
    wait_idle();

    // thresholds in the range of normal head motion
    write_reg(CFG_FD_THR, CFG_DATA_W'($urandom_range(0, 20000)));
    write_reg(CFG_DVARS_THR, CFG_DATA_W'($urandom_range(0, 6000)));
    add_random(400);
    wait_idle();

    // thresholds anywhere in their range
    write_reg(CFG_FD_THR, CFG_DATA_W'($urandom));
    write_reg(CFG_DVARS_THR, CFG_DATA_W'($urandom_range(0, 131071)));
    add_random(350);
    wait_idle();

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
src/fmsf_pkg.sv
src/frame_motion_scrub_flagger_top.sv
sim/tb_top.sv
